// File: sv/lhm_pkg.sv
`default_nettype none

package lhm_pkg;

    // field widths
    localparam int DUR_W  = 32;
    localparam int BSEL_W = 4;
    localparam int HIT_W  = 4;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;
    localparam int FRAC_W = 8;
    localparam int MEAN_W = 40;

    // default histogram size
    localparam int NUM_BUCKETS_DEF = 12;

    // minimum before the first sample
    localparam logic [DUR_W-1:0] MIN_RESET = 32'd1000000000;

    // bucket borders in microseconds
    localparam int BORDER_LEN = 11;
    localparam logic [DUR_W-1:0] BORDERS [BORDER_LEN] = '{
        32'd100, 32'd125, 32'd150, 32'd175, 32'd200, 32'd225,
        32'd250, 32'd300, 32'd350, 32'd400, 32'd800
    };

    // operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HIT,
        S_WR_HIT,
        S_RD_SEL,
        S_CAP,
        S_DIV,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// File: sv/lhm_req_if.sv
`default_nettype none

interface lhm_req_if;
    import lhm_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [DUR_W-1:0]  duration;
    logic [BSEL_W-1:0] bucket_select;

    modport source (output valid, operation, duration, bucket_select, input ready);
    modport sink   (input valid, operation, duration, bucket_select, output ready);
endinterface

`default_nettype wire

// File: sv/lhm_rsp_if.sv
`default_nettype none

interface lhm_rsp_if;
    import lhm_pkg::*;

    logic              valid;
    logic              ready;
    logic [HIT_W-1:0]  bucket_hit;
    logic [CNT_W-1:0]  bucket_count;
    logic [DUR_W-1:0]  min_duration;
    logic [DUR_W-1:0]  max_duration;
    logic [MEAN_W-1:0] mean_q8;
    logic [CNT_W-1:0]  samples_seen;

    modport source (output valid, bucket_hit, bucket_count, min_duration, max_duration,
                    mean_q8, samples_seen, input ready);
    modport sink   (input valid, bucket_hit, bucket_count, min_duration, max_duration,
                    mean_q8, samples_seen, output ready);
endinterface

`default_nettype wire

// File: sv/lhm_bucket_mem.sv
`default_nettype none

module lhm_bucket_mem #(
    parameter int NUM_BUCKETS = lhm_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [$clog2(NUM_BUCKETS)-1:0] i_waddr,
    input  wire logic [lhm_pkg::CNT_W-1:0]      i_wdata,
    input  wire logic [$clog2(NUM_BUCKETS)-1:0] i_raddr,
    output logic      [lhm_pkg::CNT_W-1:0]      o_rdata
);
    import lhm_pkg::*;

    logic [CNT_W-1:0]       r_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_vld;
    logic [CNT_W-1:0]       r_rdata;
    logic                   r_rd_vld;

    // count storage with registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // per-entry valid bits, an unwritten bucket reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

`default_nettype wire

// File: sv/lhm_mean_div.sv
`default_nettype none

module lhm_mean_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [lhm_pkg::SUM_W-1:0]  i_sum,
    input  wire logic [lhm_pkg::CNT_W-1:0]  i_cnt,
    output logic                            o_done,
    output logic      [lhm_pkg::MEAN_W-1:0] o_quot
);
    import lhm_pkg::*;

    localparam int STEP_W = $clog2(MEAN_W + 1);
    localparam int LO_W   = SUM_W - CNT_W;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [MEAN_W-1:0] r_quot;

    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        w_trial = {r_rem, r_quot[MEAN_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    // quotient register doubles as the shifting low part of the dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= '0;
                if (i_sum[SUM_W-1:LO_W] >= i_cnt) begin
                    // integer part does not fit, saturate
                    r_quot <= '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem  <= i_sum[SUM_W-1:LO_W];
                    r_quot <= {i_sum[LO_W-1:0], {FRAC_W{1'b0}}};
                    r_div  <= i_cnt;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_quot <= {r_quot[MEAN_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(MEAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: sv/latency_histogram_monitor_top.sv
// a record request goes through S_RD_HIT, S_WR_HIT, S_RD_SEL, S_CAP and S_DIV to S_OUT;
//   S_DIV waits on the serial mean divider, one quotient bit per cycle; skipped if saturated
// a read request goes through S_RD_SEL and S_CAP to S_OUT, which loads the output register
// requests: one at a time, next request taken the cycle after the result is loaded;
//   the load waits for any previous response to drain
// reset: synchronous, active low; clears the statistics and the bucket valid bits at once
`default_nettype none

module latency_histogram_monitor_top #(
    parameter int NUM_BUCKETS = lhm_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lhm_req_if.sink    i_req,
    lhm_rsp_if.source  o_rsp
);
    import lhm_pkg::*;

    localparam int AW        = $clog2(NUM_BUCKETS);
    localparam int SW        = (AW > BSEL_W) ? AW : BSEL_W;
    localparam int NB_SEARCH = (NUM_BUCKETS - 1 < BORDER_LEN) ? NUM_BUCKETS - 1 : BORDER_LEN;

    t_state             r_state;
    t_state             n_state;

    logic               r_op;
    logic [DUR_W-1:0]   r_dur;
    logic [BSEL_W-1:0]  r_sel;
    logic [AW-1:0]      r_hit;
    logic [CNT_W-1:0]   r_cnt;

    logic [DUR_W-1:0]   r_min;
    logic [DUR_W-1:0]   r_max;
    logic [SUM_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_count;
    logic [MEAN_W-1:0]  r_mean;

    logic               r_out_valid;
    logic [HIT_W-1:0]   r_out_hit;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [DUR_W-1:0]   r_out_min;
    logic [DUR_W-1:0]   r_out_max;
    logic [MEAN_W-1:0]  r_out_mean;
    logic [CNT_W-1:0]   r_out_count;

    logic [AW-1:0]      w_hit_in;
    logic [SW-1:0]      w_sel_wide;
    logic [SW-1:0]      w_hit_wide;
    logic               w_sel_ok;
    logic [AW-1:0]      w_sel_addr;
    logic               w_req_ready;
    logic               w_we;
    logic [AW-1:0]      w_raddr;
    logic [CNT_W-1:0]   w_rdata;
    logic [CNT_W-1:0]   w_wdata;
    logic               w_div_start;
    logic               w_div_done;
    logic [MEAN_W-1:0]  w_div_quot;
    logic               w_out_load;
    logic [SUM_W:0]     w_sum;

    // bucket search: first border above the duration wins
    always_comb begin
        w_hit_in = AW'(NUM_BUCKETS - 1);
        for (int i = NB_SEARCH - 1; i >= 0; i--) begin
            if (i_req.duration < BORDERS[i]) begin
                w_hit_in = AW'(i);
            end
        end
    end

    // selector range check and address
    always_comb begin
        w_sel_wide = SW'(r_sel);
        w_hit_wide = SW'(r_hit);
        w_sel_ok   = ({1'b0, w_sel_wide} < (SW + 1)'(NUM_BUCKETS));
        w_sel_addr = w_sel_wide[AW-1:0];
    end

    // saturating increment and sum
    always_comb begin
        w_wdata = (w_rdata == '1) ? w_rdata : w_rdata + 1'b1;
        w_sum   = {1'b0, r_total} + (SUM_W + 1)'(r_dur);
    end

    lhm_bucket_mem #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_hit),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lhm_mean_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (r_total),
        .i_cnt   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // sequencer: a record reads its hit bucket and writes it back, then both ops read the selected bucket
    always_comb begin
        n_state     = r_state;
        w_req_ready = 1'b0;
        w_we        = 1'b0;
        w_raddr     = r_hit;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_req_ready = 1'b1;
                if (i_req.valid) begin
                    n_state = (i_req.operation == OP_RECORD) ? S_RD_HIT : S_RD_SEL;
                end
            end
            S_RD_HIT: begin
                w_raddr = r_hit;
                n_state = S_WR_HIT;
            end
            S_WR_HIT: begin
                w_we    = 1'b1;
                n_state = S_RD_SEL;
            end
            S_RD_SEL: begin
                w_raddr     = w_sel_addr;
                w_div_start = (r_op == OP_RECORD);
                n_state     = S_CAP;
            end
            S_CAP: begin
                // a saturated mean is done already, skip the wait
                n_state = (r_op == OP_RECORD && !w_div_done) ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= MIN_RESET;
            r_max       <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_mean      <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_WR_HIT) begin
                if (r_dur < r_min) begin
                    r_min <= r_dur;
                end
                if (r_dur > r_max) begin
                    r_max <= r_dur;
                end
                r_total <= w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (w_div_done) begin
                r_mean <= w_div_quot;
            end
        end
    end

    // request capture, selected count and result register
    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_req_ready) begin
            r_op  <= i_req.operation;
            r_dur <= i_req.duration;
            r_sel <= i_req.bucket_select;
            r_hit <= w_hit_in;
        end
        if (r_state == S_CAP) begin
            r_cnt <= w_sel_ok ? w_rdata : '0;
        end
        if (w_out_load) begin
            r_out_hit   <= (r_op == OP_RECORD) ? w_hit_wide[HIT_W-1:0] : '0;
            r_out_cnt   <= r_cnt;
            r_out_min   <= r_min;
            r_out_max   <= r_max;
            r_out_mean  <= r_mean;
            r_out_count <= r_count;
        end
    end

    assign i_req.ready        = w_req_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.bucket_hit   = r_out_hit;
    assign o_rsp.bucket_count = r_out_cnt;
    assign o_rsp.min_duration = r_out_min;
    assign o_rsp.max_duration = r_out_max;
    assign o_rsp.mean_q8      = r_out_mean;
    assign o_rsp.samples_seen = r_out_count;

    // mean stays zero until the first sample
    a_mean_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_mean == '0))
        else $error("mean nonzero with no samples");

    // once a sample is in, min never exceeds max
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("min above max");

    // only a record request waits on the divider
    a_div_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_op == OP_RECORD))
        else $error("read request waiting on divider");

    // bucket write only follows the read of the same bucket
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> $past(r_state == S_RD_HIT))
        else $error("bucket write without prior read");

endmodule

`default_nettype wire

// File: tb/latency_histogram_checker.sv
`timescale 1ns / 1ps

module latency_histogram_checker #(
    parameter int NUM_BUCKETS = lhm_pkg::NUM_BUCKETS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lhm_req_if   i_req,
    lhm_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import lhm_pkg::*;

    typedef struct packed {
        logic [HIT_W-1:0]  hit;
        logic [CNT_W-1:0]  sel_count;
        logic [DUR_W-1:0]  shortest;
        logic [DUR_W-1:0]  longest;
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0]  samples;
    } t_stats;

    // shadow copy of the histogram and running statistics
    logic [CNT_W-1:0] hist [NUM_BUCKETS];
    logic [DUR_W-1:0] shortest_dur;
    logic [DUR_W-1:0] longest_dur;
    logic [SUM_W-1:0] dur_total;
    logic [CNT_W-1:0] sample_cnt;

    // statistics owed to the response channel, oldest first
    t_stats stats_due [$];

    // first bucket whose border lies above the duration, else the last one
    function automatic int bucket_of(logic [DUR_W-1:0] dur);
        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
            if (i < BORDER_LEN && dur < BORDERS[i])
                return i;
        end
        return NUM_BUCKETS - 1;
    endfunction

    // floor(sum * 256 / n), pinned to all ones when it outgrows the field
    function automatic logic [MEAN_W-1:0] mean_of(logic [SUM_W-1:0] sum,
                                                   logic [CNT_W-1:0] n);
        logic [SUM_W+FRAC_W-1:0] quot;
        if (n == '0)
            return '0;
        quot = {sum, {FRAC_W{1'b0}}} / n;
        if (quot > {MEAN_W{1'b1}})
            return '1;
        return quot[MEAN_W-1:0];
    endfunction

    // apply one request to the shadow state and snapshot the result
    function automatic t_stats account_request(logic op, logic [DUR_W-1:0] dur,
                                               logic [BSEL_W-1:0] sel);
        t_stats       snap;
        int           b;
        logic [SUM_W:0] wide;
        snap.hit = '0;
        if (op == OP_RECORD) begin
            if (dur < shortest_dur)
                shortest_dur = dur;
            if (dur > longest_dur)
                longest_dur = dur;
            b = bucket_of(dur);
            snap.hit = b[HIT_W-1:0];
            if (hist[b] != '1)
                hist[b] = hist[b] + 1'b1;
            // sum sticks at full scale instead of wrapping
            wide = dur_total + dur;
            dur_total = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
            if (sample_cnt != '1)
                sample_cnt = sample_cnt + 1'b1;
        end
        snap.sel_count = '0;
        if (sel < NUM_BUCKETS)
            snap.sel_count = hist[sel];
        snap.shortest = shortest_dur;
        snap.longest  = longest_dur;
        snap.mean     = mean_of(dur_total, sample_cnt);
        snap.samples  = sample_cnt;
        return snap;
    endfunction

    function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // predict on each accepted request, compare on each accepted response
    always @(posedge i_clk) begin : watch
        t_stats want;
        bit     ok;
        if (!i_rst_n) begin
            foreach (hist[i])
                hist[i] = '0;
            shortest_dur = MIN_RESET;
            longest_dur  = '0;
            dur_total    = '0;
            sample_cnt   = '0;
            stats_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_req.valid && i_req.ready)
                stats_due.push_back(account_request(i_req.operation, i_req.duration,
                                                    i_req.bucket_select));
            if (i_rsp.valid && i_rsp.ready) begin
                if (stats_due.size() == 0) begin
                    $display("%0t: response with no request outstanding", $time);
                    o_fail_count++;
                end else begin
                    want = stats_due.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("bucket_hit", want.hit, i_rsp.bucket_hit);
                    ok &= field_ok("bucket_count", want.sel_count, i_rsp.bucket_count);
                    ok &= field_ok("min_duration", want.shortest, i_rsp.min_duration);
                    ok &= field_ok("max_duration", want.longest, i_rsp.max_duration);
                    ok &= field_ok("mean_q8", want.mean, i_rsp.mean_q8);
                    ok &= field_ok("samples_seen", want.samples, i_rsp.samples_seen);
                    if (!ok)
                        o_fail_count++;
                end
            end
        end
        o_pending = stats_due.size();
    end

endmodule

// File: tb/latency_histogram_monitor_top_test.sv
`timescale 1ns / 1ps

module latency_histogram_monitor_top_test;
    import lhm_pkg::*;

    localparam int NB           = NUM_BUCKETS_DEF;
    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   idle_on;
    int   record_count;
    int   read_count;
    int   wide_sel_count;
    int   quiet_cycles;

    lhm_req_if req_ch ();
    lhm_rsp_if rsp_ch ();

    latency_histogram_monitor_top #(.NUM_BUCKETS(NB)) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    latency_histogram_checker #(.NUM_BUCKETS(NB)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // response side stalls at random unless idling is off
    always @(negedge clk) begin
        if (rst_n)
            rsp_ch.ready = idle_on ? ($urandom_range(99) >= 31) : 1'b1;
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // one request, with a random gap ahead of it, held until accepted
    task automatic send_request(input logic op, input logic [DUR_W-1:0] dur,
                                input logic [BSEL_W-1:0] sel);
        while (idle_on && $urandom_range(99) < 31) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.operation     = op;
        req_ch.duration      = dur;
        req_ch.bucket_select = sel;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (op == OP_RECORD)
            record_count++;
        else
            read_count++;
        if (sel >= NB)
            wide_sel_count++;
    endtask

    // durations weighted toward the histogram range and its borders
    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(999);
            5, 6:          return BORDERS[$urandom_range(BORDER_LEN - 1)]
                                  + $urandom_range(2) - 1;
            7:             return $urandom_range(1000000);
            8:             return $urandom();
            default:       return ($urandom_range(3) == 0) ? '1
                                  : MIN_RESET + $urandom_range(4) - 2;
        endcase
    endfunction

    initial begin
        logic              op;
        logic [BSEL_W-1:0] sel;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_RECORD;
        req_ch.duration      = '0;
        req_ch.bucket_select = '0;
        rsp_ch.ready         = 1'b0;
        idle_on              = 1'b1;
        quiet_cycles         = 0;
        rst_n                = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty histogram, including selects past the last bucket
        send_request(OP_READ, '1, 4'd0);
        send_request(OP_READ, 32'd5, 4'd15);
        // huge durations leave the reset minimum alone until they undercut it
        send_request(OP_RECORD, '1, 4'd11);
        send_request(OP_RECORD, MIN_RESET, 4'd12);
        send_request(OP_RECORD, MIN_RESET - 1, 4'd11);
        // zero and every border, some with the neighbor below
        send_request(OP_RECORD, 32'd0, 4'd0);
        send_request(OP_RECORD, 32'd99, 4'd0);
        send_request(OP_RECORD, 32'd100, 4'd1);
        send_request(OP_RECORD, 32'd124, 4'd1);
        send_request(OP_RECORD, 32'd125, 4'd2);
        send_request(OP_RECORD, 32'd150, 4'd3);
        send_request(OP_RECORD, 32'd175, 4'd4);
        send_request(OP_RECORD, 32'd200, 4'd5);
        send_request(OP_RECORD, 32'd225, 4'd6);
        send_request(OP_RECORD, 32'd250, 4'd7);
        send_request(OP_RECORD, 32'd300, 4'd8);
        send_request(OP_RECORD, 32'd350, 4'd9);
        send_request(OP_RECORD, 32'd400, 4'd10);
        send_request(OP_RECORD, 32'd799, 4'd10);
        send_request(OP_RECORD, 32'd800, 4'd11);
        // reads leave the statistics untouched
        send_request(OP_READ, '1, 4'd11);
        send_request(OP_READ, 32'hA5A5_5A5A, 4'd13);
        send_request(OP_READ, 32'd0, 4'd14);

        // random mix, with a stretch where neither side idles
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 500 && n < 700);
            op  = ($urandom_range(99) < 25) ? OP_READ : OP_RECORD;
            sel = ($urandom_range(99) < 85) ? BSEL_W'($urandom_range(NB - 1))
                                            : BSEL_W'($urandom_range(15));
            send_request(op, pick_duration(), sel);
        end
        idle_on      = 1'b1;
        req_ch.valid = 1'b0;

        // drain outstanding results, then watch for strays
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d record and %0d read requests, %0d selecting past the last bucket.",
                 record_count, read_count, wide_sel_count);
        $display("Durations spanned zero to full scale, with every border probed on both sides.");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
sv/lhm_pkg.sv
sv/lhm_req_if.sv
sv/lhm_rsp_if.sv
sv/lhm_bucket_mem.sv
sv/lhm_mean_div.sv
sv/latency_histogram_monitor_top.sv
tb/latency_histogram_checker.sv
tb/latency_histogram_monitor_top_test.sv
